// ===== rtl/avgp_pkg.sv =====
package avgp_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int IDX_W       = 10;
  localparam int MAX_RESULTS = 16;
  localparam int OUT_DIM_MAX = 1024;

  // register indexes, byte address is 4 times the index
  localparam logic [2:0] REG_IN_HEIGHT   = 3'd0;
  localparam logic [2:0] REG_IN_WIDTH    = 3'd1;
  localparam logic [2:0] REG_OUT_HEIGHT  = 3'd2;
  localparam logic [2:0] REG_OUT_WIDTH   = 3'd3;
  localparam logic [2:0] REG_WINDOW_SIZE = 3'd4;
  localparam logic [2:0] REG_STEP        = 3'd5;
  localparam logic [2:0] REG_PAD         = 3'd6;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== rtl/avgp_div.sv =====
module avgp_div #(
  parameter int NUM_W = 23,
  parameter int DEN_W = 7
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  neg,
  input  logic [NUM_W-1:0]      num,
  input  logic [DEN_W-1:0]      den,
  output avgp_pkg::div_status_t status,
  output avgp_pkg::sample_t     quot
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] work;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_q;
  logic             neg_q;
  logic [CW-1:0]    steps;
  logic             busy;
  logic             done;
  logic [DEN_W:0]   trial;
  logic             take;
  logic [avgp_pkg::SAMPLE_W-1:0] low;

  // restoring division, one quotient bit per cycle
  assign trial = {rem, work[NUM_W-1]};
  assign take  = trial >= {1'b0, den_q};
  assign low   = work[avgp_pkg::SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= busy && !start && (steps == CW'(1));
      if (start) begin
        busy  <= 1'b1;
        steps <= CW'(NUM_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work  <= num;
      rem   <= '0;
      den_q <= den;
      neg_q <= neg;
    end else if (busy) begin
      rem  <= take ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
      work <= {work[NUM_W-2:0], take};
    end
  end

  assign status = '{busy: busy, done: done};
  assign quot   = neg_q ? avgp_pkg::sample_t'(~low + 1'b1) : avgp_pkg::sample_t'(low);

endmodule

// ===== rtl/avg_pool_2d_exclude_pad.sv =====
// Streaming 2-D average pooling of one plane of signed Q8.8 samples in raster
// order. The last MAX_KERNEL rows sit in a line store with one read and one
// write port; when a sample closes one or more windows, each window's
// in-bounds samples are read back one per cycle, summed, and divided by their
// count (padding excluded, rounded to nearest, ties away from zero) in a
// serial divider. The first sample of a row also runs a scan for the window
// rows that close on that row; while any do, each sample runs a scan for the
// window columns that end on it. Each emitted window then passes through
// bounds, line store reads, divider and hand-off (a window wholly in the
// padding skips the reads and the divider), and the hand-off waits while the
// result output stalls. No new sample is accepted until the last window of
// the current one is handed off; at most 16 windows are emitted per sample.
// Any register write restarts the frame at row 0, column 0.
module avg_pool_2d_exclude_pad #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_KERNEL = 8,
  parameter int MAX_PAD    = 3
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [4:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  logic                    sample_valid,
  output logic                    sample_ready,
  input  avgp_pkg::sample_t       sample,
  output logic                    result_valid,
  input  logic                    result_ready,
  output avgp_pkg::sample_t       average,
  output logic [avgp_pkg::IDX_W-1:0] out_row,
  output logic [avgp_pkg::IDX_W-1:0] out_col,
  output logic                    run_last
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int SLW  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int AW   = SLW + CW;
  localparam int DEPTH = MAX_KERNEL << CW;
  localparam int SW   = avgp_pkg::SAMPLE_W + $clog2(MAX_KERNEL * MAX_KERNEL) + 1;
  localparam int CNTW = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
  localparam int TW   = 18;
  localparam int PW   = avgp_pkg::IDX_W + 1;
  localparam int NW   = $clog2(avgp_pkg::MAX_RESULTS + 1);
  localparam int IW   = $clog2(avgp_pkg::MAX_RESULTS);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RSCAN  = 4'd1;
  localparam logic [3:0] S_CSCAN  = 4'd2;
  localparam logic [3:0] S_SETUP  = 4'd3;
  localparam logic [3:0] S_BOUNDS = 4'd4;
  localparam logic [3:0] S_READ   = 4'd5;
  localparam logic [3:0] S_WAIT   = 4'd6;
  localparam logic [3:0] S_DIVGO  = 4'd7;
  localparam logic [3:0] S_DIV    = 4'd8;
  localparam logic [3:0] S_PUT    = 4'd9;

  // configuration
  logic [10:0] in_height;
  logic [10:0] in_width;
  logic [10:0] out_height;
  logic [10:0] out_width;
  logic [3:0]  window_size;
  logic [3:0]  step;
  logic [1:0]  pad;
  logic        cfg_we;

  logic [TW-1:0] dim_h, dim_w, dim_oh, dim_ow, kv, sv, pv;
  logic signed [TW-1:0] t_init;

  // frame position
  logic [RW-1:0]  row_pos;
  logic [CW-1:0]  col_pos;
  logic [SLW-1:0] pos_slot;
  logic [RW-1:0]  cur_r;
  logic [CW-1:0]  cur_c;
  logic [SLW-1:0] cur_slot;

  // trigger scan pointers
  logic [PW-1:0]        oh_ptr, ow_ptr;
  logic signed [TW-1:0] trow, tcol;
  logic [avgp_pkg::IDX_W-1:0] row_start, col_start;
  logic [NW-1:0]        rcnt, ccnt;
  logic                 row_match, col_match;

  // window walk
  logic [3:0]           state;
  logic [IW-1:0]        wi, wj, wn;
  logic [avgp_pkg::IDX_W-1:0] win_oh, win_ow;
  logic signed [TW-1:0] h0, w0;
  logic signed [TW-1:0] rlo_c, rhi_c, clo_c, chi_c, rend, cend;
  logic                 empty_c;
  logic [SLW-1:0]       d_c, slot_c;
  logic [TW-1:0]        rr, rhi, cc, clo, chi;
  logic [SLW-1:0]       rd_slot;
  logic                 rd_valid;
  logic signed [SW-1:0] sum;
  logic [CNTW-1:0]      cnt;
  avgp_pkg::sample_t    avg_res;
  logic                 last_c;
  logic                 put_fire;
  logic                 accept;

  // line store
  avgp_pkg::sample_t line_store [DEPTH];
  avgp_pkg::sample_t rd_data;
  logic [AW-1:0]     wr_addr, rd_addr;

  // divider
  logic                  div_start;
  logic                  div_neg;
  logic [SW-1:0]         div_num;
  avgp_pkg::div_status_t div_st;
  avgp_pkg::sample_t     div_quot;

  function automatic logic [TW-1:0] clamp_to(input logic signed [TW-1:0] t,
                                             input logic [TW-1:0] lim);
    logic [TW-1:0] top_v;
    top_v = lim - TW'(1);
    if (t <= 0) clamp_to = '0;
    else if ($unsigned(t) >= top_v) clamp_to = top_v;
    else clamp_to = $unsigned(t);
  endfunction

  // register port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_height   <= 11'd1;
      in_width    <= 11'd1;
      out_height  <= 11'd1;
      out_width   <= 11'd1;
      window_size <= 4'd1;
      step        <= 4'd1;
      pad         <= 2'd0;
    end else if (cfg_we) begin
      case (paddr[4:2])
        avgp_pkg::REG_IN_HEIGHT:   in_height   <= pwdata[10:0];
        avgp_pkg::REG_IN_WIDTH:    in_width    <= pwdata[10:0];
        avgp_pkg::REG_OUT_HEIGHT:  out_height  <= pwdata[10:0];
        avgp_pkg::REG_OUT_WIDTH:   out_width   <= pwdata[10:0];
        avgp_pkg::REG_WINDOW_SIZE: window_size <= pwdata[3:0];
        avgp_pkg::REG_STEP:        step        <= pwdata[3:0];
        avgp_pkg::REG_PAD:         pad         <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      avgp_pkg::REG_IN_HEIGHT:   prdata = 32'(in_height);
      avgp_pkg::REG_IN_WIDTH:    prdata = 32'(in_width);
      avgp_pkg::REG_OUT_HEIGHT:  prdata = 32'(out_height);
      avgp_pkg::REG_OUT_WIDTH:   prdata = 32'(out_width);
      avgp_pkg::REG_WINDOW_SIZE: prdata = 32'(window_size);
      avgp_pkg::REG_STEP:        prdata = 32'(step);
      avgp_pkg::REG_PAD:         prdata = 32'(pad);
      default:                   prdata = '0;
    endcase
  end

  // effective (saturated) settings
  assign dim_h  = (in_height == '0) ? TW'(1) :
                  (TW'(in_height) > TW'(MAX_HEIGHT)) ? TW'(MAX_HEIGHT) : TW'(in_height);
  assign dim_w  = (in_width == '0) ? TW'(1) :
                  (TW'(in_width) > TW'(MAX_WIDTH)) ? TW'(MAX_WIDTH) : TW'(in_width);
  assign dim_oh = (out_height == '0) ? TW'(1) :
                  (TW'(out_height) > TW'(avgp_pkg::OUT_DIM_MAX)) ?
                  TW'(avgp_pkg::OUT_DIM_MAX) : TW'(out_height);
  assign dim_ow = (out_width == '0) ? TW'(1) :
                  (TW'(out_width) > TW'(avgp_pkg::OUT_DIM_MAX)) ?
                  TW'(avgp_pkg::OUT_DIM_MAX) : TW'(out_width);
  assign kv     = (window_size == '0) ? TW'(1) :
                  (TW'(window_size) > TW'(MAX_KERNEL)) ? TW'(MAX_KERNEL) : TW'(window_size);
  assign sv     = (step == '0) ? TW'(1) : TW'(step);
  assign pv     = (TW'(pad) > TW'(MAX_PAD)) ? TW'(MAX_PAD) : TW'(pad);
  assign t_init = $signed(kv - pv - TW'(1));

  assign sample_ready = (state == S_IDLE);
  assign accept       = sample_valid && sample_ready;

  // scan tests: does the next window row / column close on this sample
  assign row_match = (TW'(oh_ptr) < dim_oh) && (rcnt < NW'(avgp_pkg::MAX_RESULTS)) &&
                     (clamp_to(trow, dim_h) == TW'(cur_r));
  assign col_match = (TW'(ow_ptr) < dim_ow) && (ccnt < NW'(avgp_pkg::MAX_RESULTS)) &&
                     (clamp_to(tcol, dim_w) == TW'(cur_c));

  assign win_oh = row_start + avgp_pkg::IDX_W'(wi);
  assign win_ow = col_start + avgp_pkg::IDX_W'(wj);

  // window bounds from its top-left corner
  assign rend    = h0 + $signed(kv);
  assign cend    = w0 + $signed(kv);
  assign rlo_c   = (h0 < 0) ? '0 : h0;
  assign clo_c   = (w0 < 0) ? '0 : w0;
  assign rhi_c   = ((rend < $signed(dim_h)) ? rend : $signed(dim_h)) - TW'(1);
  assign chi_c   = ((cend < $signed(dim_w)) ? cend : $signed(dim_w)) - TW'(1);
  assign empty_c = (rhi_c < rlo_c) || (chi_c < clo_c);
  assign d_c     = SLW'(TW'(cur_r) - $unsigned(rlo_c));
  assign slot_c  = (cur_slot >= d_c) ? cur_slot - d_c :
                   SLW'(TW'(cur_slot) + TW'(MAX_KERNEL) - TW'(d_c));

  assign last_c   = (wn == IW'(avgp_pkg::MAX_RESULTS - 1)) ||
                    ((NW'(wi) == rcnt - 1'b1) && (NW'(wj) == ccnt - 1'b1));
  assign put_fire = (state == S_PUT) && (!result_valid || result_ready);

  assign div_start = (state == S_DIVGO);
  assign div_neg   = sum[SW-1];
  assign div_num   = (div_neg ? $unsigned(-sum) : $unsigned(sum)) + SW'(cnt >> 1);

  assign wr_addr = {pos_slot, col_pos};
  assign rd_addr = {rd_slot, cc[CW-1:0]};

  always_ff @(posedge clk) begin
    if (accept) line_store[wr_addr] <= sample;
    rd_data <= line_store[rd_addr];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      row_pos  <= '0;
      col_pos  <= '0;
      pos_slot <= '0;
      rcnt     <= '0;
      ccnt     <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= (state == S_READ);
      if (cfg_we) begin
        row_pos  <= '0;
        col_pos  <= '0;
        pos_slot <= '0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cur_r    <= row_pos;
            cur_c    <= col_pos;
            cur_slot <= pos_slot;
            if (TW'(col_pos) + TW'(1) >= dim_w) begin
              col_pos <= '0;
              if (TW'(row_pos) + TW'(1) >= dim_h) begin
                row_pos  <= '0;
                pos_slot <= '0;
              end else begin
                row_pos  <= row_pos + 1'b1;
                pos_slot <= (pos_slot == SLW'(MAX_KERNEL - 1)) ? '0 : pos_slot + 1'b1;
              end
            end else begin
              col_pos <= col_pos + 1'b1;
            end
            if (col_pos == '0) begin
              if (row_pos == '0) begin
                oh_ptr    <= '0;
                trow      <= t_init;
                row_start <= '0;
              end else begin
                row_start <= oh_ptr[avgp_pkg::IDX_W-1:0];
              end
              ow_ptr <= '0;
              tcol   <= t_init;
              rcnt   <= '0;
              state  <= S_RSCAN;
            end else if (rcnt == '0) begin
              state <= S_IDLE;
            end else begin
              col_start <= ow_ptr[avgp_pkg::IDX_W-1:0];
              ccnt      <= '0;
              state     <= S_CSCAN;
            end
          end
        end
        S_RSCAN: begin
          if (row_match) begin
            rcnt   <= rcnt + 1'b1;
            oh_ptr <= oh_ptr + 1'b1;
            trow   <= trow + $signed(sv);
          end else if (rcnt == '0) begin
            state <= S_IDLE;
          end else begin
            col_start <= ow_ptr[avgp_pkg::IDX_W-1:0];
            ccnt      <= '0;
            state     <= S_CSCAN;
          end
        end
        S_CSCAN: begin
          if (col_match) begin
            ccnt   <= ccnt + 1'b1;
            ow_ptr <= ow_ptr + 1'b1;
            tcol   <= tcol + $signed(sv);
          end else if (ccnt == '0) begin
            state <= S_IDLE;
          end else begin
            wi    <= '0;
            wj    <= '0;
            wn    <= '0;
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          h0    <= $signed(TW'(win_oh) * sv - pv);
          w0    <= $signed(TW'(win_ow) * sv - pv);
          state <= S_BOUNDS;
        end
        S_BOUNDS: begin
          rr      <= $unsigned(rlo_c);
          rhi     <= $unsigned(rhi_c);
          cc      <= $unsigned(clo_c);
          clo     <= $unsigned(clo_c);
          chi     <= $unsigned(chi_c);
          rd_slot <= slot_c;
          if (empty_c) begin
            avg_res <= '0;
            state   <= S_PUT;
          end else begin
            state <= S_READ;
          end
        end
        S_READ: begin
          if (cc == chi) begin
            cc      <= clo;
            rr      <= rr + 1'b1;
            rd_slot <= (rd_slot == SLW'(MAX_KERNEL - 1)) ? '0 : rd_slot + 1'b1;
            if (rr == rhi) state <= S_WAIT;
          end else begin
            cc <= cc + 1'b1;
          end
        end
        S_WAIT:  state <= S_DIVGO;
        S_DIVGO: state <= (cnt == '0) ? S_PUT : S_DIV;
        S_DIV: begin
          if (div_st.done) begin
            avg_res <= div_quot;
            state   <= S_PUT;
          end
        end
        S_PUT: begin
          if (put_fire) begin
            if (last_c) begin
              state <= S_IDLE;
            end else begin
              wn <= wn + 1'b1;
              if (NW'(wj) + 1'b1 == ccnt) begin
                wj <= '0;
                wi <= wi + 1'b1;
              end else begin
                wj <= wj + 1'b1;
              end
              state <= S_SETUP;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // window accumulation
  always_ff @(posedge clk) begin
    if (state == S_BOUNDS) begin
      sum <= '0;
      cnt <= '0;
    end else if (rd_valid) begin
      sum <= sum + SW'(rd_data);
      cnt <= cnt + 1'b1;
    end
  end

  avgp_div #(
    .NUM_W(SW),
    .DEN_W(CNTW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .neg   (div_neg),
    .num   (div_num),
    .den   (cnt),
    .status(div_st),
    .quot  (div_quot)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (put_fire) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (put_fire) begin
      average  <= avg_res;
      out_row  <= win_oh;
      out_col  <= win_ow;
      run_last <= last_c;
    end
  end

  a_row_start_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && sample_ready && (col_pos == '0)) |=> !sample_ready)
    else $error("request at row start accepted but block stayed idle");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_st.busy)
    else $error("divider restarted while busy");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (TW'(rd_slot) < TW'(MAX_KERNEL)))
    else $error("line store slot out of range");

  a_window_range: assert property (@(posedge clk) disable iff (rst)
    put_fire |-> ((TW'(win_oh) < dim_oh) && (TW'(win_ow) < dim_ow)))
    else $error("window index beyond output size");

endmodule
